// File: rtl/core/spq_pkg.sv
package spq_pkg;

	// Queue capacity and derived widths
	localparam int QUEUE_DEPTH = 64;
	localparam int ADDR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int KEY_W       = 32;

	// Request type codes
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Error codes reported with each result
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_FULL  = 2'd1;
	localparam logic [1:0] ERR_EMPTY = 2'd2;

	// Request and result payloads
	typedef struct packed {
		logic                     req_type;
		logic signed [KEY_W-1:0]  key;
	} spq_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0]  top_key;
		logic [6:0]               entry_count;
		logic                     is_empty;
		logic [1:0]               req_error;
	} spq_rsp_t;

	// Datapath operation for one cycle
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_INS_READ,
		OP_INS_KEY,
		OP_INS_SHIFT,
		OP_DEL_READ,
		OP_DEL_SHIFT,
		OP_DEL_DONE
	} spq_op_t;

	// Controller to datapath
	typedef struct packed {
		spq_op_t     op;
		logic        respond;
		logic [1:0]  err;
	} spq_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic idx_zero;
		logic key_le;
		logic del_end;
	} spq_stat_t;

endpackage

// File: rtl/core/spq_ram.sv
module spq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/spq_dp.sv
module spq_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::spq_req_t req,
	input  spq_pkg::spq_cmd_t cmd,
	output spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_rsp_t rsp
);

	logic [spq_pkg::CNT_W-1:0]         count_q, cnt_nx;
	logic [spq_pkg::CNT_W-1:0]         idx_q, idx_nx, idx_m1;
	logic signed [spq_pkg::KEY_W-1:0]  key_q, key_nx;
	logic signed [spq_pkg::KEY_W-1:0]  top_q, top_nx;
	logic signed [spq_pkg::KEY_W-1:0]  rd_data;
	logic signed [spq_pkg::KEY_W-1:0]  wr_data;
	logic [spq_pkg::ADDR_W-1:0]        waddr, raddr;
	logic                              we;
	spq_pkg::spq_rsp_t                 rsp_q;

	assign idx_m1 = idx_q - spq_pkg::CNT_W'(1);

	spq_ram #(
		.WIDTH (spq_pkg::KEY_W),
		.DEPTH (spq_pkg::QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_data),
		.raddr (raddr),
		.rdata (rd_data)
	);

	// Next-state and memory access for the current operation
	always_comb begin
		we      = 1'b0;
		waddr   = idx_q[spq_pkg::ADDR_W-1:0];
		raddr   = idx_q[spq_pkg::ADDR_W-1:0];
		wr_data = key_q;
		idx_nx  = idx_q;
		cnt_nx  = count_q;
		top_nx  = top_q;
		key_nx  = key_q;
		case (cmd.op)
			spq_pkg::OP_LOAD: begin
				key_nx = req.key;
				idx_nx = (req.req_type == spq_pkg::REQ_POP) ? spq_pkg::CNT_W'(1) : count_q;
			end
			spq_pkg::OP_INS_READ: begin
				raddr = idx_m1[spq_pkg::ADDR_W-1:0];
			end
			spq_pkg::OP_INS_KEY: begin
				we     = 1'b1;
				cnt_nx = count_q + spq_pkg::CNT_W'(1);
				if (idx_q == '0) begin
					top_nx = key_q;
				end
			end
			spq_pkg::OP_INS_SHIFT: begin
				we      = 1'b1;
				wr_data = rd_data;
				idx_nx  = idx_m1;
			end
			spq_pkg::OP_DEL_READ: begin
				raddr = idx_q[spq_pkg::ADDR_W-1:0];
			end
			spq_pkg::OP_DEL_SHIFT: begin
				we      = 1'b1;
				waddr   = idx_m1[spq_pkg::ADDR_W-1:0];
				wr_data = rd_data;
				idx_nx  = idx_q + spq_pkg::CNT_W'(1);
				if (idx_q == spq_pkg::CNT_W'(1)) begin
					top_nx = rd_data;
				end
			end
			spq_pkg::OP_DEL_DONE: begin
				cnt_nx = count_q - spq_pkg::CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= cnt_nx;
		end
	end

	// Working registers and result
	always_ff @(posedge clk) begin
		idx_q <= idx_nx;
		key_q <= key_nx;
		top_q <= top_nx;
		if (cmd.respond) begin
			rsp_q.top_key     <= (cnt_nx == '0) ? '0 : top_nx;
			rsp_q.entry_count <= 7'(cnt_nx);
			rsp_q.is_empty    <= (cnt_nx == '0);
			rsp_q.req_error   <= cmd.err;
		end
	end

	// Status to the controller
	assign stat.full     = (count_q == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.idx_zero = (idx_q == '0);
	assign stat.key_le   = (rd_data >= key_q);
	assign stat.del_end  = (idx_q == count_q);

	assign rsp = rsp_q;

	// Count stays within capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH))
		else $error("entry count above capacity");

	// Key is written only when there is room
	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == spq_pkg::OP_INS_KEY |-> !stat.full)
		else $error("insert into full queue");

	// Removal only from a non-empty queue
	a_del_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == spq_pkg::OP_DEL_DONE |-> !stat.empty)
		else $error("removal from empty queue");

	// Insert shifting never walks below entry zero
	a_ins_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == spq_pkg::OP_INS_READ || cmd.op == spq_pkg::OP_INS_SHIFT)
		|-> !stat.idx_zero)
		else $error("insert index underflow");

endmodule

// File: rtl/core/spq_ctrl.sv
module spq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               req_type,
	input  spq_pkg::spq_stat_t stat,
	output spq_pkg::spq_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_CHK,
		ST_INS_CMP,
		ST_DEL_CHK,
		ST_DEL_MOV
	} state_t;

	state_t state_q, state_nx;
	logic   busy_q, done_q;

	// Sequencing and per-cycle datapath commands
	always_comb begin
		state_nx    = state_q;
		cmd.op      = spq_pkg::OP_NONE;
		cmd.respond = 1'b0;
		cmd.err     = spq_pkg::ERR_NONE;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (req_type == spq_pkg::REQ_PUSH) begin
						if (stat.full) begin
							cmd.respond = 1'b1;
							cmd.err     = spq_pkg::ERR_FULL;
						end else begin
							cmd.op   = spq_pkg::OP_LOAD;
							state_nx = ST_INS_CHK;
						end
					end else begin
						if (stat.empty) begin
							cmd.respond = 1'b1;
							cmd.err     = spq_pkg::ERR_EMPTY;
						end else begin
							cmd.op   = spq_pkg::OP_LOAD;
							state_nx = ST_DEL_CHK;
						end
					end
				end
			end
			ST_INS_CHK: begin
				if (stat.idx_zero) begin
					cmd.op      = spq_pkg::OP_INS_KEY;
					cmd.respond = 1'b1;
					state_nx    = ST_IDLE;
				end else begin
					cmd.op   = spq_pkg::OP_INS_READ;
					state_nx = ST_INS_CMP;
				end
			end
			ST_INS_CMP: begin
				if (stat.key_le) begin
					cmd.op      = spq_pkg::OP_INS_KEY;
					cmd.respond = 1'b1;
					state_nx    = ST_IDLE;
				end else begin
					cmd.op   = spq_pkg::OP_INS_SHIFT;
					state_nx = ST_INS_CHK;
				end
			end
			ST_DEL_CHK: begin
				if (stat.del_end) begin
					cmd.op      = spq_pkg::OP_DEL_DONE;
					cmd.respond = 1'b1;
					state_nx    = ST_IDLE;
				end else begin
					cmd.op   = spq_pkg::OP_DEL_READ;
					state_nx = ST_DEL_MOV;
				end
			end
			ST_DEL_MOV: begin
				cmd.op   = spq_pkg::OP_DEL_SHIFT;
				state_nx = ST_DEL_CHK;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// State and registered handshake outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			busy_q  <= (state_nx != ST_IDLE);
			done_q  <= cmd.respond;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// A result always ends the request
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while busy");

	// Busy tracks the state register
	a_busy_state: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q == (state_q != ST_IDLE))
		else $error("busy out of step with state");

endmodule

// File: rtl/core/sorted_priority_queue_top.sv
// Sorted max priority queue of spq_pkg::QUEUE_DEPTH signed 32-bit keys held in
// one single-port-read RAM in descending order. A request is taken when start
// is high and busy is low; its result appears on rsp for exactly one cycle with
// done high and cannot be held off, so capture it on that cycle. Busy stays high
// while a push moves entries down or a pop moves entries up. Each moved entry
// costs a read step and a write step, because the RAM read is registered. A
// push into a full queue or a pop on an empty one is answered on the next
// cycle with an error code and busy stays low. No clearing pass is needed
// after reset.
module sorted_priority_queue_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  spq_pkg::spq_req_t req,
	output logic              busy,
	output logic              done,
	output spq_pkg::spq_rsp_t rsp
);

	spq_pkg::spq_cmd_t  cmd;
	spq_pkg::spq_stat_t stat;

	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req_type (req.req_type),
		.stat     (stat),
		.cmd      (cmd),
		.busy     (busy),
		.done     (done)
	);

	spq_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.stat   (stat),
		.rsp    (rsp)
	);

endmodule

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;

	// Cycles with neither a request nor a result taken before the run is given up
	localparam int STALL_LIMIT  = 4000;
	// Longest busy stretch of one request, plus margin
	localparam int SETTLE_CYCLES = 2 * spq_pkg::QUEUE_DEPTH + 8;
	localparam int RANDOM_ITEMS  = 400;

	typedef struct {
		spq_pkg::spq_req_t r;
		bit                typed;
		spq_pkg::spq_rsp_t rsp;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic              done;
	spq_pkg::spq_req_t req;
	spq_pkg::spq_rsp_t rsp;

	// Mirror of the queue contents, in descending order
	logic signed [spq_pkg::KEY_W-1:0] mirror_keys [spq_pkg::QUEUE_DEPTH];
	int                               mirror_count;

	spq_pkg::spq_rsp_t expected_rsp [$];
	stim_row_t         stim_table [$];
	int                fail_cnt;
	int                stall_cnt;
	int                random_sent;
	bit                no_gaps;

	sorted_priority_queue_top u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Apply one request to the mirror and return the answer it should produce
	function automatic spq_pkg::spq_rsp_t apply_request(spq_pkg::spq_req_t r);
		spq_pkg::spq_rsp_t                res;
		int                               pos;
		logic signed [spq_pkg::KEY_W-1:0] k;
		res.req_error = spq_pkg::ERR_NONE;
		k = $signed(r.key);
		if (r.req_type == spq_pkg::REQ_PUSH) begin
			if (mirror_count >= spq_pkg::QUEUE_DEPTH) begin
				res.req_error = spq_pkg::ERR_FULL;
			end else begin
				// equal keys stay ahead of the new one
				pos = 0;
				while (pos < mirror_count && mirror_keys[pos] >= k)
					pos++;
				for (int i = mirror_count; i > pos; i--)
					mirror_keys[i] = mirror_keys[i - 1];
				mirror_keys[pos] = k;
				mirror_count++;
			end
		end else begin
			if (mirror_count == 0) begin
				res.req_error = spq_pkg::ERR_EMPTY;
			end else begin
				for (int i = 1; i < mirror_count; i++)
					mirror_keys[i - 1] = mirror_keys[i];
				mirror_count--;
			end
		end
		res.top_key     = (mirror_count != 0) ? mirror_keys[0] : '0;
		res.is_empty    = (mirror_count == 0);
		res.entry_count = 7'(mirror_count);
		return res;
	endfunction

	function automatic stim_row_t row(logic op, logic signed [spq_pkg::KEY_W-1:0] key,
			bit typed, logic signed [spq_pkg::KEY_W-1:0] top, int cnt, logic emp,
			logic [1:0] err);
		stim_row_t s;
		s.r.req_type        = op;
		s.r.key             = key;
		s.typed             = typed;
		s.rsp.top_key       = top;
		s.rsp.entry_count   = 7'(cnt);
		s.rsp.is_empty      = emp;
		s.rsp.req_error     = err;
		return s;
	endfunction

	// Mostly extremes and a narrow band so that duplicates are common
	function automatic logic signed [spq_pkg::KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return '0;
			3: return -32'sd1;
			4, 5: return $signed($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_cnt++;
	endtask

	// Hand one request to the block, with an occasional gap before it
	task automatic send(spq_pkg::spq_req_t r, bit typed, spq_pkg::spq_rsp_t typed_rsp);
		spq_pkg::spq_rsp_t want;
		if (!no_gaps && $urandom_range(0, 99) < 15) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do @(posedge clk); while (busy);
		want = apply_request(r);
		expected_rsp.push_back(typed ? typed_rsp : want);
	endtask

	task automatic send_random(logic op, logic signed [spq_pkg::KEY_W-1:0] key);
		spq_pkg::spq_req_t r;
		stim_row_t         unused;
		r.req_type = op;
		r.key      = key;
		unused     = row(spq_pkg::REQ_PUSH, '0, 1'b0, '0, 0, 1'b0, spq_pkg::ERR_NONE);
		no_gaps    = (random_sent >= 150 && random_sent < 250);
		send(r, 1'b0, unused.rsp);
		random_sent++;
	endtask

	// Hold off the sender until every answer is in
	task automatic wait_drained();
		if (start)
			start <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	// Result checker
	always @(posedge clk) begin
		spq_pkg::spq_rsp_t want;
		if (arst_n && done) begin
			if (expected_rsp.size() == 0) begin
				report($sformatf("result with no request waiting, top_key %0d",
					rsp.top_key));
			end else begin
				want = expected_rsp.pop_front();
				if (rsp.top_key !== want.top_key)
					report($sformatf("top_key %0d, want %0d", $signed(rsp.top_key),
						$signed(want.top_key)));
				if (rsp.entry_count !== want.entry_count)
					report($sformatf("entry_count %0d, want %0d", rsp.entry_count,
						want.entry_count));
				if (rsp.is_empty !== want.is_empty)
					report($sformatf("is_empty %0b, want %0b", rsp.is_empty, want.is_empty));
				if (rsp.req_error !== want.req_error)
					report($sformatf("req_error %0d, want %0d", rsp.req_error,
						want.req_error));
			end
		end
	end

	// Watchdog on lack of progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("sorted_priority_queue_top regression: fail");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	initial begin
		int phase_idx;
		int phase;
		arst_n       = 1'b0;
		start        = 1'b0;
		req          = '0;
		fail_cnt     = 0;
		stall_cnt    = 0;
		random_sent  = 0;
		no_gaps      = 1'b0;
		mirror_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: pop on empty, extremes, head and tail inserts, ties, drain past empty
		stim_table.push_back(row(spq_pkg::REQ_POP,  '0,            1'b1, '0,
			0, 1'b1, spq_pkg::ERR_EMPTY));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sh7fffffff, 1'b1, 32'sh7fffffff,
			1, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sh80000000, 1'b1, 32'sh7fffffff,
			2, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, '0,            1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, -32'sd1,       1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sh7fffffff, 1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sh80000000, 1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sd5,        1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_POP,  32'shffffffff, 1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_POP,  '0,            1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_POP,  '0,            1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sd5,        1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_PUSH, 32'sd5,        1'b0, '0,
			0, 1'b0, spq_pkg::ERR_NONE));
		repeat (6)
			stim_table.push_back(row(spq_pkg::REQ_POP, '0, 1'b0, '0,
				0, 1'b0, spq_pkg::ERR_NONE));
		stim_table.push_back(row(spq_pkg::REQ_POP,  '0,            1'b1, '0,
			0, 1'b1, spq_pkg::ERR_EMPTY));
		foreach (stim_table[i])
			send(stim_table[i].r, stim_table[i].typed, stim_table[i].rsp);
		wait_drained();

		// Random phases: fill to overflow first, then drain past empty, then a mix
		phase_idx = 0;
		while (random_sent < RANDOM_ITEMS) begin
			phase = (phase_idx < 2) ? phase_idx + 1 : $urandom_range(0, 3);
			case (phase)
				1: begin
					while (mirror_count < spq_pkg::QUEUE_DEPTH)
						send_random(spq_pkg::REQ_PUSH, pick_key());
					repeat ($urandom_range(1, 3))
						send_random(spq_pkg::REQ_PUSH, pick_key());
				end
				2: begin
					while (mirror_count > 0)
						send_random(spq_pkg::REQ_POP, $urandom);
					repeat ($urandom_range(1, 2))
						send_random(spq_pkg::REQ_POP, $urandom);
				end
				3: begin
					// narrow key band for many ties
					repeat ($urandom_range(10, 30))
						send_random(($urandom_range(0, 1) == 0) ? spq_pkg::REQ_PUSH
							: spq_pkg::REQ_POP, $signed($urandom_range(0, 3)));
				end
				default: begin
					repeat ($urandom_range(10, 30))
						send_random(($urandom_range(0, 99) < 60) ? spq_pkg::REQ_PUSH
							: spq_pkg::REQ_POP, pick_key());
				end
			endcase
			if (phase_idx == 0 || $urandom_range(0, 3) == 0)
				wait_drained();
			phase_idx++;
		end

		// Let the last answers arrive, then give the block time to settle
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("sorted_priority_queue_top regression: pass");
		end else begin
			$display("sorted_priority_queue_top regression: fail");
		end
		$finish;
	end

endmodule

// File: sorted_priority_queue_top.f
rtl/core/spq_pkg.sv
rtl/core/spq_ram.sv
rtl/core/spq_dp.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue_top.sv
bench/tb.sv
